### sv/pdlb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdlb_pkg
// Shared types, field positions and helpers for the diagnostic LED blinker.
// ----------------------------------------------------------------------------
package pdlb_pkg;

	// number of diagnostic flags that may become pending (1..6)
	localparam int NUM_DIAGNOSTICS = 6;

	localparam int FLAG_W      = 6;
	localparam int SLOT_W      = 3;
	localparam int ENTRY_COUNT = 6;
	localparam int ENTRY_W     = 34;
	localparam int DELAY_W     = 12;
	localparam int DUR_W       = 16;
	localparam int ADDR_W      = 6;
	localparam int DATA_W      = 64;

	localparam logic [FLAG_W-1:0] FLAG_MASK = FLAG_W'((1 << NUM_DIAGNOSTICS) - 1);

	// entry packing
	localparam int DELAY_LSB = 6;
	localparam int DUR_LSB   = 18;

	// request kinds
	localparam logic REQ_NOTIFY = 1'b0;
	localparam logic REQ_TICK   = 1'b1;

	// LED modes; code 3 behaves as off
	localparam logic [1:0] LED_OFF    = 2'd0;
	localparam logic [1:0] LED_ON     = 2'd1;
	localparam logic [1:0] LED_TOGGLE = 2'd2;

	typedef logic [ENTRY_W-1:0] entry_t;

	localparam entry_t ENTRY_RESET [ENTRY_COUNT] = '{
		34'd786444802, 34'd1048577642, 34'd65537634,
		34'd131075232, 34'd65537642,   34'd6555204
	};

	// lowest set bit index, 0 when empty
	function automatic logic [SLOT_W-1:0] lowest_flag(input logic [FLAG_W-1:0] set);
		logic [SLOT_W-1:0] idx;
		idx = '0;
		for (int i = FLAG_W - 1; i >= 0; i--) begin
			if (set[i]) idx = SLOT_W'(i);
		end
		return idx;
	endfunction

	// apply off/on/toggle per color; bit 0 red, 1 green, 2 blue
	function automatic logic [2:0] apply_pattern(input entry_t e, input logic [2:0] led);
		logic [2:0] res;
		res = led;
		for (int c = 0; c < 3; c++) begin
			case (e[2*c +: 2])
				LED_ON:     res[c] = 1'b1;
				LED_TOGGLE: res[c] = ~res[c];
				default:    res[c] = 1'b0;
			endcase
		end
		return res;
	endfunction

	function automatic logic [DELAY_W-1:0] entry_delay(input entry_t e);
		logic [DELAY_W-1:0] d;
		d = e[DELAY_LSB +: DELAY_W];
		return (d == '0) ? DELAY_W'(1) : d;
	endfunction

	function automatic logic [DUR_W-1:0] entry_duration(input entry_t e);
		return e[DUR_LSB +: DUR_W];
	endfunction

endpackage

### sv/priority_diagnostic_led_blinker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_diagnostic_led_blinker_unit
// Pending-flag priority scheduler that drives an RGB diagnostic blink pattern.
// ----------------------------------------------------------------------------
// Accepts one request per clock (notify or 1 ms tick) unless req_stall is
// high, and returns exactly one response per request, in order. A request
// is captured in an input register; while it waits there the whole state
// update (priority encode of the pending set, duration/delay compares and
// the pattern apply) runs in one short combinational pass that loads the
// state and the response register at once. Throughput is one request per
// cycle with no response stall. A response turns valid once its request
// has gone through the input and response registers. The input register
// lets one more request in while a response is stalled. Entries sit at byte
// address 8*i on the APB port and are read live at every repeat point.
module priority_diagnostic_led_blinker_unit
	import pdlb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// request channel
	input  logic              req_valid,
	output logic              req_stall,
	input  logic              req_type,
	input  logic [FLAG_W-1:0] notify_bits,
	// response channel
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output logic              led_red,
	output logic              led_green,
	output logic              led_blue,
	output logic              showing,
	output logic [SLOT_W-1:0] shown_index,
	output logic [FLAG_W-1:0] pending_flags,
	// configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	// ---------------- configuration registers ----------------
	entry_t            entry_q [ENTRY_COUNT];
	logic [SLOT_W-1:0] reg_idx;
	logic              cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:3];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRY_COUNT; i++) entry_q[i] <= ENTRY_RESET[i];
		end else if (cfg_wr && (reg_idx < SLOT_W'(ENTRY_COUNT))) begin
			entry_q[reg_idx] <= pwdata[ENTRY_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx < SLOT_W'(ENTRY_COUNT)) prdata = DATA_W'(entry_q[reg_idx]);
	end

	// ---------------- input register ----------------
	logic              valid_s1;
	logic              req_type_s1;
	logic [FLAG_W-1:0] notify_bits_s1;
	logic              advance;

	// stage 1 moves on whenever the response register is free or being taken
	assign advance   = !rsp_valid || !rsp_stall;
	assign req_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			req_type_s1    <= req_type;
			notify_bits_s1 <= notify_bits;
		end
	end

	// ---------------- blinker state ----------------
	logic [FLAG_W-1:0]  flag_q;
	logic               busy_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [DUR_W-1:0]   elapsed_q;
	logic [DELAY_W-1:0] delay_q;
	logic [2:0]         led_q;

	logic [FLAG_W-1:0]  flag_d;
	logic               busy_d;
	logic [SLOT_W-1:0]  slot_d;
	logic [DUR_W-1:0]   elapsed_d;
	logic [DELAY_W-1:0] delay_d;
	logic [2:0]         led_d;

	// repeat-point inputs
	logic               do_rep;
	logic [SLOT_W-1:0]  rep_slot;
	logic [DUR_W-1:0]   rep_elapsed;
	logic [2:0]         rep_led;
	entry_t             rep_entry;
	logic [DUR_W-1:0]   elapsed_inc;

	assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + DUR_W'(1);

	always_comb begin
		flag_d      = flag_q;
		busy_d      = busy_q;
		slot_d      = slot_q;
		elapsed_d   = elapsed_q;
		delay_d     = delay_q;
		led_d       = led_q;
		do_rep      = 1'b0;
		rep_slot    = slot_q;
		rep_elapsed = elapsed_inc;
		rep_led     = led_q;
		rep_entry   = '0;

		if (req_type_s1 == REQ_NOTIFY) begin
			flag_d = flag_q | (notify_bits_s1 & FLAG_MASK);
		end else if (!busy_q) begin
			// start: the start tick itself adds no time
			if (flag_q != '0) begin
				do_rep      = 1'b1;
				rep_slot    = lowest_flag(flag_q);
				rep_elapsed = '0;
				rep_led     = '0;
			end
		end else begin
			if (delay_q <= DELAY_W'(1)) begin
				do_rep = 1'b1;
			end else begin
				elapsed_d = elapsed_inc;
				delay_d   = delay_q - DELAY_W'(1);
			end
		end

		if (rep_slot < SLOT_W'(ENTRY_COUNT)) rep_entry = entry_q[rep_slot];

		if (do_rep) begin
			// duration over, or a higher-priority flag arrived: end the show
			if ((rep_elapsed >= entry_duration(rep_entry)) ||
			    (lowest_flag(flag_q) != rep_slot)) begin
				led_d     = '0;
				flag_d    = flag_q & ~(FLAG_W'(1) << rep_slot);
				busy_d    = 1'b0;
				slot_d    = '0;
				elapsed_d = '0;
				delay_d   = '0;
			end else begin
				led_d     = apply_pattern(rep_entry, rep_led);
				busy_d    = 1'b1;
				slot_d    = rep_slot;
				elapsed_d = rep_elapsed;
				delay_d   = entry_delay(rep_entry);
			end
		end
	end

	logic step;
	assign step = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q    <= '0;
			busy_q    <= 1'b0;
			slot_q    <= '0;
			elapsed_q <= '0;
			delay_q   <= '0;
			led_q     <= '0;
		end else if (step) begin
			flag_q    <= flag_d;
			busy_q    <= busy_d;
			slot_q    <= slot_d;
			elapsed_q <= elapsed_d;
			delay_q   <= delay_d;
			led_q     <= led_d;
		end
	end

	// ---------------- response register ----------------
	logic              rsp_valid_q;
	logic [2:0]        rsp_led_q;
	logic              rsp_busy_q;
	logic [SLOT_W-1:0] rsp_slot_q;
	logic [FLAG_W-1:0] rsp_flags_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			rsp_led_q   <= led_d;
			rsp_busy_q  <= busy_d;
			rsp_slot_q  <= busy_d ? slot_d : '0;
			rsp_flags_q <= flag_d;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign led_red       = rsp_led_q[0];
	assign led_green     = rsp_led_q[1];
	assign led_blue      = rsp_led_q[2];
	assign showing       = rsp_busy_q;
	assign shown_index   = rsp_slot_q;
	assign pending_flags = rsp_flags_q;

	// ---------------- assertions ----------------
	// the flag being shown stays pending until its show ends
	a_slot_pending: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> flag_q[slot_q])
		else $error("shown flag not pending");

	// idle means LEDs dark and no delay running
	a_idle_dark: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (led_q == '0 && delay_q == '0 && elapsed_q == '0))
		else $error("idle state not cleared");

	// a shown slot is always a real table entry
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (slot_q < SLOT_W'(ENTRY_COUNT)))
		else $error("slot out of range");

	// stalling the request side only happens with the input register full
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (valid_s1 && rsp_valid_q && rsp_stall))
		else $error("spurious request stall");

endmodule

### tb/sv/tb_priority_diagnostic_led_blinker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_priority_diagnostic_led_blinker_unit
// Self-checking bench for the diagnostic LED blinker. Ticks and flag notifies
// go in through the request channel. A cycle-free model of the scheduler
// predicts the LED state after every request. Each returned response is
// compared field by field against that prediction. The entry table is
// rewritten over APB between phases and read back.
// ----------------------------------------------------------------------------
package blinker_check_pkg;
	import pdlb_pkg::*;

	typedef struct packed {
		logic              red;
		logic              green;
		logic              blue;
		logic              showing;
		logic [SLOT_W-1:0] index;
		logic [FLAG_W-1:0] pending;
	} led_state_t;

	class blinker_scoreboard;
		entry_t            diag_table [ENTRY_COUNT];
		logic [FLAG_W-1:0] flags;
		logic              busy;
		logic [SLOT_W-1:0] slot;
		logic [DUR_W-1:0]  elapsed;
		logic [DELAY_W-1:0] delay_left;
		logic [2:0]        leds;       // bit 0 red, 1 green, 2 blue
		led_state_t        led_states_due [$];
		int                errors;
		int                checked;

		function new();
			diag_table[0] = 34'd786444802;
			diag_table[1] = 34'd1048577642;
			diag_table[2] = 34'd65537634;
			diag_table[3] = 34'd131075232;
			diag_table[4] = 34'd65537642;
			diag_table[5] = 34'd6555204;
			flags      = '0;
			busy       = 1'b0;
			slot       = '0;
			elapsed    = '0;
			delay_left = '0;
			leds       = '0;
			errors     = 0;
			checked    = 0;
		endfunction

		function void write_entry(int idx, logic [DATA_W-1:0] value);
			if (idx < ENTRY_COUNT)
				diag_table[idx] = value[ENTRY_W-1:0];
		endfunction

		function logic [SLOT_W-1:0] first_pending(logic [FLAG_W-1:0] set);
			for (int i = 0; i < FLAG_W; i++)
				if (set[i])
					return SLOT_W'(i);
			return '0;
		endfunction

		function void finish_show();
			leds       = '0;
			flags[slot] = 1'b0;
			busy       = 1'b0;
			slot       = '0;
			elapsed    = '0;
			delay_left = '0;
		endfunction

		// duration check, pattern, then the priority check
		function void repeat_point();
			entry_t             e;
			logic [DELAY_W-1:0] d;
			e = (slot < ENTRY_COUNT) ? diag_table[slot] : '0;
			if (elapsed >= e[DUR_LSB +: DUR_W]) begin
				finish_show();
				return;
			end
			for (int c = 0; c < 3; c++) begin
				case (e[2*c +: 2])
					LED_ON:     leds[c] = 1'b1;
					LED_TOGGLE: leds[c] = ~leds[c];
					default:    leds[c] = 1'b0;
				endcase
			end
			if (first_pending(flags) != slot) begin
				finish_show();
				return;
			end
			d = e[DELAY_LSB +: DELAY_W];
			delay_left = (d == '0) ? DELAY_W'(1) : d;
		endfunction

		function void note_request(logic kind, logic [FLAG_W-1:0] bits);
			led_state_t r;
			if (kind == REQ_NOTIFY) begin
				flags = flags | (bits & FLAG_MASK);
			end else if (!busy) begin
				if (flags != '0) begin
					slot    = first_pending(flags);
					busy    = 1'b1;
					elapsed = '0;
					leds    = '0;
					repeat_point();
				end
			end else begin
				if (elapsed != '1)
					elapsed = elapsed + 1'b1;
				if (delay_left <= 1) begin
					delay_left = '0;
					repeat_point();
				end else begin
					delay_left = delay_left - 1'b1;
				end
			end
			r.red     = leds[0];
			r.green   = leds[1];
			r.blue    = leds[2];
			r.showing = busy;
			r.index   = busy ? slot : '0;
			r.pending = flags;
			led_states_due.push_back(r);
		endfunction

		task report_mismatch(string what, logic [63:0] want, logic [63:0] got);
			errors++;
			$display("MISMATCH %s: expected %0h got %0h at %0t", what, want, got, $time);
		endtask

		task check_response(led_state_t got);
			led_state_t want;
			if (led_states_due.size() == 0) begin
				report_mismatch("response with nothing due", '0, got);
				return;
			end
			want = led_states_due.pop_front();
			checked++;
			if (got.red !== want.red)
				report_mismatch("led_red", want.red, got.red);
			if (got.green !== want.green)
				report_mismatch("led_green", want.green, got.green);
			if (got.blue !== want.blue)
				report_mismatch("led_blue", want.blue, got.blue);
			if (got.showing !== want.showing)
				report_mismatch("showing", want.showing, got.showing);
			if (got.index !== want.index)
				report_mismatch("shown_index", want.index, got.index);
			if (got.pending !== want.pending)
				report_mismatch("pending_flags", want.pending, got.pending);
		endtask
	endclass

endpackage

module tb_priority_diagnostic_led_blinker_unit;
	import pdlb_pkg::*;
	import blinker_check_pkg::*;

	localparam int CLK_HALF      = 2;
	localparam int RESET_CYCLES  = 12;
	localparam int IDLE_PCT      = 31;     // chance of an idle cycle on each side
	localparam int HOLD_CYCLES   = 300;    // receiver hold-off for the pressure phase
	localparam int STALL_LIMIT   = 2000;   // cycles without progress before giving up
	localparam int SETTLE_CYCLES = 4;      // settle time after reset and after the last response
	localparam int ENTRY_STRIDE  = 8;      // 34-bit entries sit on 8-byte addresses
	localparam logic [1:0] LED_SPARE = 2'd3;   // unused mode code, must act as off

	logic              clk = 1'b0;
	logic              arst_n;
	logic              req_valid;
	logic              req_stall;
	logic              req_type;
	logic [FLAG_W-1:0] notify_bits;
	logic              rsp_valid;
	logic              rsp_stall;
	logic              led_red;
	logic              led_green;
	logic              led_blue;
	logic              showing;
	logic [SLOT_W-1:0] shown_index;
	logic [FLAG_W-1:0] pending_flags;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	blinker_scoreboard sb;
	led_state_t        seen;

	// calm turns random idling off on both sides; hold_request asks the
	// receiver for one long hold-off
	bit calm         = 1'b0;
	bit hold_request = 1'b0;

	int n_requests  = 0;
	int n_ticks     = 0;
	int n_notifies  = 0;
	int n_writes    = 0;
	int quiet       = 0;

	always #CLK_HALF clk = ~clk;

	priority_diagnostic_led_blinker_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.req_type      (req_type),
		.notify_bits   (notify_bits),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.led_red       (led_red),
		.led_green     (led_green),
		.led_blue      (led_blue),
		.showing       (showing),
		.shown_index   (shown_index),
		.pending_flags (pending_flags),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	// ------------------------------------------------------------------------
	// Monitor: everything is sampled at the rising edge, so all values seen
	// here are the ones that were stable during the cycle just ended. The
	// request is noted before the response is checked; a request can never
	// come back in the cycle it is taken.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				sb.note_request(req_type, notify_bits);
				n_requests++;
				if (req_type == REQ_TICK)
					n_ticks++;
				else
					n_notifies++;
			end
			if (rsp_valid && !rsp_stall) begin
				seen.red     = led_red;
				seen.green   = led_green;
				seen.blue    = led_blue;
				seen.showing = showing;
				seen.index   = shown_index;
				seen.pending = pending_flags;
				sb.check_response(seen);
			end
			// watchdog: any handshake or APB transfer counts as progress
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel)
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("Watchdog: no progress for %0d cycles at %0t", STALL_LIMIT, $time);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Receiver: random stalls, except in calm phases. On request it holds
	// off for a long stretch so the input register fills and the block has
	// to stall its request side.
	// ------------------------------------------------------------------------
	initial begin
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
				rsp_stall <= 1'b0;
			end else begin
				rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	// Offer one request and return at the edge where it is taken. An idle
	// gap, when drawn, is placed before the request with junk on the fields.
	task automatic send_request(input logic kind, input logic [FLAG_W-1:0] bits);
		if (!calm && $urandom_range(99) < IDLE_PCT) begin
			req_valid   <= 1'b0;
			req_type    <= 1'($urandom_range(1));
			notify_bits <= FLAG_W'($urandom_range(63));
			@(posedge clk);
			while ($urandom_range(99) < IDLE_PCT)
				@(posedge clk);
		end
		req_valid   <= 1'b1;
		req_type    <= kind;
		notify_bits <= bits;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	// Mostly ticks, which is what moves the scheduler along; single-flag
	// notifies make priority aborts likely, full random masks are the noise.
	task automatic run_random(input int count);
		int pick;
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(99);
			if (pick < 70)
				send_request(REQ_TICK, FLAG_W'($urandom_range(63)));
			else if (pick < 90)
				send_request(REQ_NOTIFY, FLAG_W'(1) << $urandom_range(FLAG_W - 1));
			else
				send_request(REQ_NOTIFY, FLAG_W'($urandom_range(63)));
		end
	endtask

	// Tick until nothing is shown or pending; a late extra tick is harmless.
	task automatic tick_until_clear(input int limit);
		int k;
		k = 0;
		while ((sb.busy || sb.flags != '0) && k < limit) begin
			send_request(REQ_TICK, '0);
			k++;
		end
	endtask

	// Drop valid, then wait for every outstanding response plus SETTLE_CYCLES.
	task automatic wait_idle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (sb.led_states_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input int idx, input logic [DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(idx * ENTRY_STRIDE);
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		sb.write_entry(idx, value);
		n_writes++;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apb_read(input int idx, output logic [DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_W'(idx * ENTRY_STRIDE);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		value = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Read every entry back and compare with the predictor's copy.
	task automatic check_table();
		logic [DATA_W-1:0] v;
		for (int i = 0; i < ENTRY_COUNT; i++) begin
			apb_read(i, v);
			if (v[ENTRY_W-1:0] !== sb.diag_table[i])
				sb.report_mismatch($sformatf("diag_entry_%0d readback", i),
					sb.diag_table[i], v[ENTRY_W-1:0]);
		end
	endtask

	function automatic logic [DATA_W-1:0] make_entry(
		input logic [1:0] red, input logic [1:0] green, input logic [1:0] blue,
		input logic [DELAY_W-1:0] gap_ms, input logic [DUR_W-1:0] dur_ms);
		return DATA_W'({dur_ms, gap_ms, blue, green, red});
	endfunction

	// Short delays and durations keep flags cycling through the scheduler.
	task automatic load_random_table(input int max_delay, input int max_dur);
		for (int i = 0; i < ENTRY_COUNT; i++)
			apb_write(i, make_entry(2'($urandom_range(3)), 2'($urandom_range(3)),
				2'($urandom_range(3)), DELAY_W'($urandom_range(max_delay)),
				DUR_W'($urandom_range(max_dur))));
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		sb = new();
		arst_n      = 1'b0;
		req_valid   <= 1'b0;
		req_type    <= REQ_NOTIFY;
		notify_bits <= '0;
		psel        <= 1'b0;
		penable     <= 1'b0;
		pwrite      <= 1'b0;
		paddr       <= '0;
		pwdata      <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (SETTLE_CYCLES) @(posedge clk);

		// reset values of the table
		check_table();

		// directed: zero delay on 0, zero duration on 1, code 3 on 3
		apb_write(0, make_entry(LED_ON, LED_TOGGLE, LED_SPARE, 12'd0, 16'd3));
		apb_write(1, make_entry(LED_ON, LED_ON, LED_ON, 12'd2, 16'd0));
		apb_write(2, make_entry(LED_TOGGLE, LED_TOGGLE, LED_TOGGLE, 12'd1, 16'd4));
		apb_write(3, make_entry(LED_SPARE, LED_SPARE, LED_SPARE, 12'd3, 16'd10));
		apb_write(4, make_entry(LED_ON, LED_OFF, LED_ON, 12'd2, 16'd6));
		apb_write(5, make_entry(LED_OFF, LED_ON, LED_TOGGLE, 12'd1, 16'd2));
		check_table();

		send_request(REQ_TICK, '1);            // tick with nothing pending
		send_request(REQ_NOTIFY, '0);          // empty notify
		send_request(REQ_NOTIFY, 6'b100000);   // lowest priority flag
		send_request(REQ_TICK, '0);            // starts slot 5
		send_request(REQ_NOTIFY, 6'b000001);   // higher priority while showing
		send_request(REQ_TICK, '0);            // repeat point aborts slot 5
		repeat (4) send_request(REQ_TICK, '0); // slot 0 starts and runs out
		send_request(REQ_NOTIFY, 6'b000010);
		send_request(REQ_TICK, '0);            // zero duration: start and finish
		send_request(REQ_NOTIFY, '1);          // every flag at once
		repeat (12) send_request(REQ_TICK, '0);
		wait_idle();

		// random traffic with random idling on both sides
		load_random_table(4, 20);
		check_table();
		run_random(110);
		wait_idle();

		// back-pressure: receiver holds off while requests keep coming;
		// this table is rewritten while a pattern may still be showing
		load_random_table(3, 12);
		hold_request = 1'b1;
		run_random(110);
		wait_idle();

		// long stretch with no idling at all
		load_random_table(2, 8);
		calm = 1'b1;
		run_random(60);
		calm = 1'b0;
		wait_idle();

		// extremes: all-ones entry, all-zero entry, writes past the table
		apb_write(0, '1);
		apb_write(1, '0);
		apb_write(2, make_entry(LED_TOGGLE, LED_ON, LED_OFF, 12'd1, 16'd1));
		apb_write(ENTRY_COUNT, '1);
		apb_write(ENTRY_COUNT + 1, '1);
		check_table();
		// slot 0 runs for the longest duration but repeats every tick, so a
		// later table rewrite can end it on the next tick
		apb_write(0, make_entry(LED_SPARE, LED_SPARE, LED_SPARE, 12'd1, 16'hFFFF));
		run_random(30);
		wait_idle();

		// clear out whatever is still queued
		load_random_table(3, 5);
		calm = 1'b1;
		tick_until_clear(500);
		calm = 1'b0;
		wait_idle();

		// last random phase on a fresh table
		load_random_table(4, 20);
		run_random(40);
		wait_idle();

		if (sb.led_states_due.size() != 0)
			sb.report_mismatch("responses never returned", '0, sb.led_states_due.size());

		$display("Run: %0d requests (%0d ticks, %0d notifies), %0d responses, %0d writes",
			n_requests, n_ticks, n_notifies, sb.checked, n_writes);
		$display("Covered aborts, zero delay/duration, spare mode code, live table rewrites, back-pressure");
		if (sb.errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
